// File: rtl/esfs_pkg.sv
// Package for the eased servo flap sequencer: widths, codes, phase and
// controller types, command/status structs and the angle helper functions.
// No dependencies.
package esfs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int T_W       = FRAC_BITS + 1;
    localparam int DUR_W     = 16;
    localparam int NOW_W     = 32;
    localparam int ANG_W     = 8;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int CNT_W     = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;
    localparam int ACC_W     = FRAC_BITS + 11;

    localparam logic [T_W-1:0]   ONE      = T_W'(1) << FRAC_BITS;
    localparam logic [T_W-1:0]   HALF     = T_W'(1) << (FRAC_BITS - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS - 1);
    localparam logic [ANG_W-1:0] ANGLE_MAX = 8'd180;

    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_OPEN  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLOSE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TIME        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_OPEN_TIME   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TIME       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_CLOSED_TIME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MIN         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MAX         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_MIN        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_MAX        = 3'd7;

    typedef enum logic [2:0] {
        PH_CLOSED      = 3'd0,
        PH_OPENING     = 3'd1,
        PH_HOLD_OPEN   = 3'd2,
        PH_OPENED      = 3'd3,
        PH_CLOSING     = 3'd4,
        PH_HOLD_CLOSED = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_SEL,
        S_SQ,
        S_CUBE,
        S_SCALE,
        S_FINISH
    } fsm_state_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_step;
        logic sel;
        logic square;
        logic cube;
        logic scale;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic out_free;
    } dp_status_t;

    function automatic logic [ANG_W-1:0] sat_angle(input logic [ANG_W-1:0] a);
        return (a > ANGLE_MAX) ? ANGLE_MAX : a;
    endfunction

    // floor((lo*ONE + e*(hi-lo)) / ONE), clamped to [0, 180]
    function automatic logic [ANG_W-1:0] scale_angle(
        input logic [T_W-1:0]   e,
        input logic [ANG_W-1:0] lo,
        input logic [ANG_W-1:0] hi
    );
        logic signed [9:0]             diff;
        logic signed [ACC_W-1:0]       acc;
        logic [ACC_W-FRAC_BITS-1:0]    whole;
        diff = $signed({2'b00, hi}) - $signed({2'b00, lo});
        acc  = $signed({{(ACC_W-FRAC_BITS-ANG_W){1'b0}}, lo, {FRAC_BITS{1'b0}}})
             + $signed({{(ACC_W-T_W){1'b0}}, e})
             * $signed({{(ACC_W-10){diff[9]}}, diff});
        if (acc[ACC_W-1])
            whole = '0;
        else
            whole = acc[ACC_W-1:FRAC_BITS];
        return (whole > (ACC_W-FRAC_BITS)'(ANGLE_MAX)) ? ANGLE_MAX : whole[ANG_W-1:0];
    endfunction

endpackage

// File: rtl/esfs_req_if.sv
// Request channel: request code and millisecond time.
// Depends on esfs_pkg.
interface esfs_req_if;
    logic                            valid;
    logic                            ready;
    logic [esfs_pkg::REQ_W-1:0]      req_type;
    logic [esfs_pkg::NOW_W-1:0]      now_ms;

    modport source (output valid, req_type, now_ms, input ready);
    modport sink   (input valid, req_type, now_ms, output ready);
endinterface

// File: rtl/esfs_res_if.sv
// Result channel: servo angles, write flag, drive enable and phase.
// Depends on esfs_pkg.
interface esfs_res_if;
    logic                            valid;
    logic                            ready;
    logic [esfs_pkg::ANG_W-1:0]      left_angle;
    logic [esfs_pkg::ANG_W-1:0]      right_angle;
    logic                            angle_written;
    logic                            drive_enable;
    logic [2:0]                      phase;

    modport source (output valid, left_angle, right_angle, angle_written, drive_enable,
                    phase, input ready);
    modport sink   (input valid, left_angle, right_angle, angle_written, drive_enable,
                    phase, output ready);
endinterface

// File: rtl/esfs_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on esfs_pkg.
interface esfs_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [esfs_pkg::CFG_IDX_W-1:0]     index;
    logic [esfs_pkg::CFG_DAT_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/esfs_ctrl.sv
// Sequencer controller: steps one transaction through evaluate and, if the datapath
// needs it, divide, ease and scale, then commits the result. Depends on esfs_pkg.
module esfs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output esfs_pkg::ctrl_cmd_t    cmd,
    input  esfs_pkg::dp_status_t   status
);

    esfs_pkg::fsm_state_t             state_reg, state_next;
    logic [esfs_pkg::CNT_W-1:0]       cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= esfs_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            esfs_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = esfs_pkg::S_EVAL;
                end
            end
            esfs_pkg::S_EVAL:
            begin
                cmd.eval = 1'b1;
                cnt_next = '0;
                state_next = status.need_div ? esfs_pkg::S_DIV : esfs_pkg::S_FINISH;
            end
            esfs_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == esfs_pkg::CNT_LAST)
                    state_next = esfs_pkg::S_SEL;
            end
            esfs_pkg::S_SEL:
            begin
                cmd.sel    = 1'b1;
                state_next = esfs_pkg::S_SQ;
            end
            esfs_pkg::S_SQ:
            begin
                cmd.square = 1'b1;
                state_next = esfs_pkg::S_CUBE;
            end
            esfs_pkg::S_CUBE:
            begin
                cmd.cube   = 1'b1;
                state_next = esfs_pkg::S_SCALE;
            end
            esfs_pkg::S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = esfs_pkg::S_FINISH;
            end
            esfs_pkg::S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = esfs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = esfs_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == esfs_pkg::S_EVAL))
        else $error("accepted transaction did not enter evaluate");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == esfs_pkg::S_DIV && cnt_reg == esfs_pkg::CNT_LAST)
        |=> (state_reg == esfs_pkg::S_SEL))
        else $error("divider did not finish after its last step");

    a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (state_reg == esfs_pkg::S_IDLE && in_ready))
        else $error("controller not idle after commit");
`endif

endmodule

// File: rtl/esfs_dp.sv
// Sequencer datapath: configuration and phase state, elapsed-time check,
// restoring divider, cubic ease, angle scaling, result register. Depends on esfs_pkg.
module esfs_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  esfs_pkg::ctrl_cmd_t               cmd,
    output esfs_pkg::dp_status_t              status,
    input  logic [esfs_pkg::REQ_W-1:0]        req_type,
    input  logic [esfs_pkg::NOW_W-1:0]        now_ms,
    input  logic                              cfg_we,
    input  logic [esfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [esfs_pkg::CFG_DAT_W-1:0]    cfg_data,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [esfs_pkg::ANG_W-1:0]        left_angle,
    output logic [esfs_pkg::ANG_W-1:0]        right_angle,
    output logic                              angle_written,
    output logic                              drive_enable,
    output logic [2:0]                        phase
);

    localparam int F = esfs_pkg::FRAC_BITS;

    // configuration
    logic [esfs_pkg::DUR_W-1:0] open_time_reg, hold_open_time_reg;
    logic [esfs_pkg::DUR_W-1:0] close_time_reg, hold_closed_time_reg;
    logic [esfs_pkg::ANG_W-1:0] left_min_reg, left_max_reg, right_min_reg, right_max_reg;

    // sequencer state
    esfs_pkg::phase_t           phase_reg, phase_next;
    logic [esfs_pkg::NOW_W-1:0] start_reg, start_next;
    logic                       drive_reg, drive_next;

    // transaction
    logic [esfs_pkg::REQ_W-1:0] req_reg;
    logic [esfs_pkg::NOW_W-1:0] now_reg;
    logic [esfs_pkg::DUR_W-1:0] dur_reg, rem_reg;
    logic                       le_reg, ge_reg;
    logic [F-1:0]               q_reg, y_reg, sq_reg;
    logic                       hi_reg;
    logic [esfs_pkg::T_W-1:0]   e_reg;
    logic [esfs_pkg::ANG_W-1:0] scl_left_reg, scl_right_reg;

    // result
    logic                       res_valid_reg;
    logic [esfs_pkg::ANG_W-1:0] res_left_reg, res_right_reg;
    logic                       res_written_reg, res_drive_reg;
    logic [2:0]                 res_phase_reg;

    logic [esfs_pkg::NOW_W-1:0] dt;
    logic [esfs_pkg::DUR_W-1:0] dur_raw, dur;
    logic                       moving, le_now, ge_now;
    logic [esfs_pkg::DUR_W:0]   rem2;
    logic                       rem_ge;
    logic [esfs_pkg::T_W-1:0]   t_val, x_val, y_val;
    logic                       x_hi;
    logic [2*F-1:0]             sq_prod, cube_prod;
    logic [F-1:0]               c_val;
    logic [esfs_pkg::T_W-1:0]   four_c;
    logic                       wrote;
    logic [esfs_pkg::ANG_W-1:0] la, ra;
    logic                       open_end;

    always_comb
    begin
        moving = (phase_reg == esfs_pkg::PH_OPENING) || (phase_reg == esfs_pkg::PH_CLOSING);
        dt = now_reg - start_reg;
        case (phase_reg)
            esfs_pkg::PH_OPENING:     dur_raw = open_time_reg;
            esfs_pkg::PH_CLOSING:     dur_raw = close_time_reg;
            esfs_pkg::PH_HOLD_OPEN:   dur_raw = hold_open_time_reg;
            esfs_pkg::PH_HOLD_CLOSED: dur_raw = hold_closed_time_reg;
            default:                  dur_raw = hold_closed_time_reg;
        endcase
        dur    = (dur_raw == '0) ? esfs_pkg::DUR_W'(1) : dur_raw;
        le_now = dt <= {{(esfs_pkg::NOW_W-esfs_pkg::DUR_W){1'b0}}, dur};
        ge_now = dt >= {{(esfs_pkg::NOW_W-esfs_pkg::DUR_W){1'b0}}, dur};
        status.need_div = (req_reg == esfs_pkg::REQ_TICK) && moving && le_now;
        status.out_free = !res_valid_reg || res_ready;
    end

    // restoring divide step: remainder stays at or below the duration
    always_comb
    begin
        rem2   = {rem_reg, 1'b0};
        rem_ge = rem2 >= {1'b0, dur_reg};
    end

    // ease input: fold to the lower half; square and cube products
    always_comb
    begin
        t_val = (le_reg && ge_reg) ? esfs_pkg::ONE : {1'b0, q_reg};
        x_val = (phase_reg == esfs_pkg::PH_OPENING) ? t_val : esfs_pkg::ONE - t_val;
        x_hi  = x_val >= esfs_pkg::HALF;
        y_val = x_hi ? esfs_pkg::ONE - x_val : x_val;
        sq_prod   = y_reg * y_reg;
        cube_prod = sq_reg * y_reg;
        c_val     = cube_prod[2*F-1:F];
        four_c    = esfs_pkg::T_W'({c_val, 2'b00});
    end

    always_comb
    begin
        phase_next = phase_reg;
        start_next = start_reg;
        drive_next = drive_reg;
        wrote      = 1'b0;
        la         = '0;
        ra         = '0;
        open_end   = (phase_reg == esfs_pkg::PH_HOLD_OPEN);
        case (req_reg)
            esfs_pkg::REQ_OPEN:
            begin
                phase_next = esfs_pkg::PH_OPENING;
                start_next = now_reg;
            end
            esfs_pkg::REQ_CLOSE:
            begin
                phase_next = esfs_pkg::PH_CLOSING;
                start_next = now_reg;
            end
            esfs_pkg::REQ_TICK:
            begin
                case (phase_reg)
                    esfs_pkg::PH_OPENING, esfs_pkg::PH_CLOSING:
                    begin
                        if (le_reg)
                        begin
                            drive_next = 1'b1;
                            wrote      = 1'b1;
                            la         = scl_left_reg;
                            ra         = scl_right_reg;
                        end
                        if (ge_reg)
                        begin
                            phase_next = (phase_reg == esfs_pkg::PH_OPENING)
                                       ? esfs_pkg::PH_HOLD_OPEN : esfs_pkg::PH_HOLD_CLOSED;
                            start_next = now_reg;
                        end
                    end
                    esfs_pkg::PH_HOLD_OPEN, esfs_pkg::PH_HOLD_CLOSED:
                    begin
                        if (le_reg)
                        begin
                            drive_next = 1'b1;
                            wrote      = 1'b1;
                            la = esfs_pkg::sat_angle(open_end ? left_max_reg : left_min_reg);
                            ra = esfs_pkg::sat_angle(open_end ? right_max_reg : right_min_reg);
                        end
                        if (ge_reg)
                        begin
                            drive_next = 1'b0;
                            phase_next = open_end ? esfs_pkg::PH_OPENED : esfs_pkg::PH_CLOSED;
                            start_next = now_reg;
                        end
                    end
                    esfs_pkg::PH_CLOSED, esfs_pkg::PH_OPENED:
                    begin
                        drive_next = 1'b0;
                    end
                    default:
                    begin
                        drive_next = drive_reg;
                    end
                endcase
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_time_reg        <= 16'd1000;
            hold_open_time_reg   <= 16'd500;
            close_time_reg       <= 16'd1000;
            hold_closed_time_reg <= 16'd500;
            left_min_reg         <= 8'd0;
            left_max_reg         <= 8'd90;
            right_min_reg        <= 8'd180;
            right_max_reg        <= 8'd90;
            phase_reg            <= esfs_pkg::PH_CLOSING;
            start_reg            <= '0;
            drive_reg            <= 1'b0;
            res_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    esfs_pkg::CFG_OPEN_TIME:        open_time_reg        <= cfg_data;
                    esfs_pkg::CFG_HOLD_OPEN_TIME:   hold_open_time_reg   <= cfg_data;
                    esfs_pkg::CFG_CLOSE_TIME:       close_time_reg       <= cfg_data;
                    esfs_pkg::CFG_HOLD_CLOSED_TIME: hold_closed_time_reg <= cfg_data;
                    esfs_pkg::CFG_LEFT_MIN:         left_min_reg  <= cfg_data[esfs_pkg::ANG_W-1:0];
                    esfs_pkg::CFG_LEFT_MAX:         left_max_reg  <= cfg_data[esfs_pkg::ANG_W-1:0];
                    esfs_pkg::CFG_RIGHT_MIN:        right_min_reg <= cfg_data[esfs_pkg::ANG_W-1:0];
                    esfs_pkg::CFG_RIGHT_MAX:        right_max_reg <= cfg_data[esfs_pkg::ANG_W-1:0];
                    default:                        open_time_reg <= open_time_reg;
                endcase
            end
            if (cmd.commit)
            begin
                phase_reg     <= phase_next;
                start_reg     <= start_next;
                drive_reg     <= drive_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            now_reg <= now_ms;
        end
        if (cmd.eval)
        begin
            dur_reg <= dur;
            le_reg  <= le_now;
            ge_reg  <= ge_now;
            rem_reg <= dt[esfs_pkg::DUR_W-1:0];
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? esfs_pkg::DUR_W'(rem2 - {1'b0, dur_reg})
                              : rem2[esfs_pkg::DUR_W-1:0];
            q_reg   <= {q_reg[F-2:0], rem_ge};
        end
        if (cmd.sel)
        begin
            y_reg  <= y_val[F-1:0];
            hi_reg <= x_hi;
        end
        if (cmd.square)
            sq_reg <= sq_prod[2*F-1:F];
        if (cmd.cube)
            e_reg <= hi_reg ? esfs_pkg::ONE - four_c : four_c;
        if (cmd.scale)
        begin
            scl_left_reg  <= esfs_pkg::scale_angle(e_reg, left_min_reg, left_max_reg);
            scl_right_reg <= esfs_pkg::scale_angle(e_reg, right_min_reg, right_max_reg);
        end
        if (cmd.commit)
        begin
            res_left_reg    <= la;
            res_right_reg   <= ra;
            res_written_reg <= wrote;
            res_drive_reg   <= drive_next;
            res_phase_reg   <= phase_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign left_angle    = res_left_reg;
    assign right_angle   = res_right_reg;
    assign angle_written = res_written_reg;
    assign drive_enable  = res_drive_reg;
    assign phase         = res_phase_reg;

`ifndef SYNTH
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> res_valid_reg)
        else $error("commit did not present a result");

    a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_written_reg) |-> (res_left_reg == '0 && res_right_reg == '0))
        else $error("angles nonzero without a write");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_written_reg)
        |-> (res_left_reg <= esfs_pkg::ANGLE_MAX && res_right_reg <= esfs_pkg::ANGLE_MAX))
        else $error("written angle out of range");
`endif

endmodule

// File: rtl/eased_servo_flap_sequencer_core.sv
// Eased servo flap sequencer, top level.
// Depends on esfs_pkg, esfs_req_if, esfs_res_if, esfs_cfg_if, esfs_ctrl, esfs_dp.
//
// Channels: req carries a request (tick, open or close) with the current
// millisecond time; res returns one transaction per request with both servo
// angles, the write flag, the drive enable and the phase after the step;
// cfg writes the duration and angle registers by index and is always ready.
// Configuration must be written while no request is in flight; the block does not enforce this.
//
// Sequencing: one request at a time; the next is taken the cycle
// after the result is registered. Commands, unused codes, holding and resting
// phases and a moving tick past its duration go from evaluate straight to
// finish. A moving tick within its duration passes through the one-bit-per-cycle
// restoring divider that normalizes elapsed time to the phase duration,
// followed by the select, the two cubic multiplies and the angle scale.
// Reset loads the register defaults and puts the flap in the closing phase
// with start time zero and the drive released.
// Stall: the result sits in an output register; the next request is taken
// while it waits, and is held at its final cycle until that register frees.
module eased_servo_flap_sequencer_core (
    input  logic         clk,
    input  logic         rst_n,
    esfs_req_if.sink     req,
    esfs_res_if.source   res,
    esfs_cfg_if.sink     cfg
);

    esfs_pkg::ctrl_cmd_t   cmd;
    esfs_pkg::dp_status_t  status;

    assign cfg.ready = 1'b1;

    esfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .cmd      (cmd),
        .status   (status)
    );

    esfs_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .req_type      (req.req_type),
        .now_ms        (req.now_ms),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .res_valid     (res.valid),
        .res_ready     (res.ready),
        .left_angle    (res.left_angle),
        .right_angle   (res.right_angle),
        .angle_written (res.angle_written),
        .drive_enable  (res.drive_enable),
        .phase         (res.phase)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for eased_servo_flap_sequencer_core: drives requests and
// register writes, predicts every result with a local flap model and checks them.
// Depends on esfs_pkg, esfs_req_if, esfs_res_if, esfs_cfg_if and the core RTL.
module tb_top;

    localparam int unsigned     CYCLE_LIMIT = 300000;
    localparam int              FB          = esfs_pkg::FRAC_BITS;
    localparam longint unsigned UNIT_Q      = 64'd1 << FB;
    localparam logic [1:0]      REQ_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now;
    } flap_req_t;

    typedef struct packed {
        logic [7:0] left_angle;
        logic [7:0] right_angle;
        logic       angle_written;
        logic       drive_enable;
        logic [2:0] phase;
    } flap_result_t;

    logic clk;
    logic rst_n = 1'b0;

    esfs_req_if req_ch();
    esfs_res_if res_ch();
    esfs_cfg_if cfg_ch();

    eased_servo_flap_sequencer_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // flap model: registers and state
    logic [15:0]      open_ms        = 16'd1000;
    logic [15:0]      hold_open_ms   = 16'd500;
    logic [15:0]      close_ms       = 16'd1000;
    logic [15:0]      hold_closed_ms = 16'd500;
    logic [7:0]       lmin           = 8'd0;
    logic [7:0]       lmax           = 8'd90;
    logic [7:0]       rmin           = 8'd180;
    logic [7:0]       rmax           = 8'd90;
    esfs_pkg::phase_t flap_ph        = esfs_pkg::PH_CLOSING;
    logic [31:0]      flap_start     = '0;
    logic             flap_drive     = 1'b0;

    flap_req_t    pending_q[$];
    flap_result_t expect_q[$];
    flap_req_t    nxt_req;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    logic        rx_hold     = 1'b0;
    logic        squeeze_go  = 1'b0;
    int unsigned cycles      = 0;
    int unsigned issued      = 0;
    int unsigned checked     = 0;
    int unsigned mismatches  = 0;
    int unsigned settings    = 1;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint unsigned dur_or_one(logic [15:0] v);
        return (v == 16'd0) ? 64'd1 : {48'd0, v};
    endfunction

    function automatic longint unsigned cube_frac(longint unsigned x);
        longint unsigned sq;
        sq = (x * x) >> FB;
        return (sq * x) >> FB;
    endfunction

    function automatic longint unsigned eased(longint unsigned t);
        longint unsigned tc;
        tc = (t > UNIT_Q) ? UNIT_Q : t;
        if (tc < (UNIT_Q >> 1))
            return 4 * cube_frac(tc);
        return UNIT_Q - 4 * cube_frac(UNIT_Q - tc);
    endfunction

    function automatic logic [7:0] clamp_deg(longint unsigned a);
        return (a > 180) ? 8'd180 : a[7:0];
    endfunction

    function automatic logic [7:0] blend_deg(longint unsigned e, logic [7:0] lo,
                                             logic [7:0] hi);
        longint l;
        longint h;
        longint ee;
        longint acc;
        l   = {56'd0, lo};
        h   = {56'd0, hi};
        ee  = e;
        acc = l * longint'(UNIT_Q) + ee * (h - l);
        if (acc < 0)
            acc = 0;
        return clamp_deg(acc >> FB);
    endfunction

    // advance the flap model by one request and return the expected transaction
    function automatic flap_result_t flap_step(logic [1:0] kind, logic [31:0] now);
        flap_result_t    r;
        logic [31:0]     dt;
        longint unsigned dtl;
        longint unsigned d;
        longint unsigned t;
        longint unsigned e;
        logic            opening;
        logic            open_end;
        r = '0;
        case (kind)
            esfs_pkg::REQ_OPEN:
            begin
                flap_ph    = esfs_pkg::PH_OPENING;
                flap_start = now;
            end
            esfs_pkg::REQ_CLOSE:
            begin
                flap_ph    = esfs_pkg::PH_CLOSING;
                flap_start = now;
            end
            esfs_pkg::REQ_TICK:
            begin
                dt  = now - flap_start;
                dtl = {32'd0, dt};
                case (flap_ph)
                    esfs_pkg::PH_OPENING, esfs_pkg::PH_CLOSING:
                    begin
                        opening = (flap_ph == esfs_pkg::PH_OPENING);
                        d = dur_or_one(opening ? open_ms : close_ms);
                        if (dtl <= d)
                        begin
                            t = (dtl << FB) / d;
                            e = eased(opening ? t : UNIT_Q - t);
                            flap_drive      = 1'b1;
                            r.left_angle    = blend_deg(e, lmin, lmax);
                            r.right_angle   = blend_deg(e, rmin, rmax);
                            r.angle_written = 1'b1;
                        end
                        if (dtl >= d)
                        begin
                            flap_ph    = opening ? esfs_pkg::PH_HOLD_OPEN
                                                 : esfs_pkg::PH_HOLD_CLOSED;
                            flap_start = now;
                        end
                    end
                    esfs_pkg::PH_HOLD_OPEN, esfs_pkg::PH_HOLD_CLOSED:
                    begin
                        open_end = (flap_ph == esfs_pkg::PH_HOLD_OPEN);
                        d = dur_or_one(open_end ? hold_open_ms : hold_closed_ms);
                        if (dtl <= d)
                        begin
                            flap_drive      = 1'b1;
                            r.left_angle    = clamp_deg(open_end ? lmax : lmin);
                            r.right_angle   = clamp_deg(open_end ? rmax : rmin);
                            r.angle_written = 1'b1;
                        end
                        if (dtl >= d)
                        begin
                            flap_drive = 1'b0;
                            flap_ph    = open_end ? esfs_pkg::PH_OPENED : esfs_pkg::PH_CLOSED;
                            flap_start = now;
                        end
                    end
                    esfs_pkg::PH_CLOSED, esfs_pkg::PH_OPENED:
                        flap_drive = 1'b0;
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.drive_enable = flap_drive;
        r.phase        = flap_ph;
        return r;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.req_type <= esfs_pkg::REQ_TICK;
            req_ch.now_ms   <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expect_q.push_back(flap_step(req_ch.req_type, req_ch.now_ms));
                issued++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    nxt_req = pending_q.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.req_type <= nxt_req.kind;
                    req_ch.now_ms   <= nxt_req.now;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : res_mon
        flap_result_t got;
        flap_result_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got.left_angle    = res_ch.left_angle;
                got.right_angle   = res_ch.right_angle;
                got.angle_written = res_ch.angle_written;
                got.drive_enable  = res_ch.drive_enable;
                got.phase         = res_ch.phase;
                if (expect_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected transaction L=%0d R=%0d W=%0b D=%0b P=%0d",
                                 got.left_angle, got.right_angle, got.angle_written,
                                 got.drive_enable, got.phase);
                end
                else
                begin
                    want = expect_q.pop_front();
                    checked++;
                    if (got.left_angle !== want.left_angle
                        || got.right_angle !== want.right_angle
                        || got.angle_written !== want.angle_written
                        || got.drive_enable !== want.drive_enable
                        || got.phase !== want.phase)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: transaction %0d exp L=%0d R=%0d W=%0b D=%0b ",
                                      "P=%0d got L=%0d R=%0d W=%0b D=%0b P=%0d"},
                                     checked, want.left_angle, want.right_angle,
                                     want.angle_written, want.drive_enable, want.phase,
                                     got.left_angle, got.right_angle, got.angle_written,
                                     got.drive_enable, got.phase);
                    end
                end
            end
            res_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // register model follows the write channel
    always @(posedge clk)
    begin
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
        begin
            case (cfg_ch.index)
                esfs_pkg::CFG_OPEN_TIME:        open_ms        = cfg_ch.data;
                esfs_pkg::CFG_HOLD_OPEN_TIME:   hold_open_ms   = cfg_ch.data;
                esfs_pkg::CFG_CLOSE_TIME:       close_ms       = cfg_ch.data;
                esfs_pkg::CFG_HOLD_CLOSED_TIME: hold_closed_ms = cfg_ch.data;
                esfs_pkg::CFG_LEFT_MIN:         lmin           = cfg_ch.data[7:0];
                esfs_pkg::CFG_LEFT_MAX:         lmax           = cfg_ch.data[7:0];
                esfs_pkg::CFG_RIGHT_MIN:        rmin           = cfg_ch.data[7:0];
                esfs_pkg::CFG_RIGHT_MAX:        rmax           = cfg_ch.data[7:0];
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // long receiver stall while requests keep coming
    initial
    begin
        wait (squeeze_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic push_req(input logic [1:0] kind, input logic [31:0] now);
        flap_req_t it;
        it.kind = kind;
        it.now  = now;
        pending_q.push_back(it);
    endtask

    // wait until no request is queued, in flight or awaiting its transaction
    task automatic settle();
        @(negedge clk);
        while (pending_q.size() != 0 || req_ch.valid || expect_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [15:0] o, input logic [15:0] ho,
                                 input logic [15:0] c, input logic [15:0] hc,
                                 input logic [7:0] l0, input logic [7:0] l1,
                                 input logic [7:0] r0, input logic [7:0] r1);
        settle();
        write_reg(esfs_pkg::CFG_OPEN_TIME, o);
        write_reg(esfs_pkg::CFG_HOLD_OPEN_TIME, ho);
        write_reg(esfs_pkg::CFG_CLOSE_TIME, c);
        write_reg(esfs_pkg::CFG_HOLD_CLOSED_TIME, hc);
        write_reg(esfs_pkg::CFG_LEFT_MIN, {8'd0, l0});
        write_reg(esfs_pkg::CFG_LEFT_MAX, {8'd0, l1});
        write_reg(esfs_pkg::CFG_RIGHT_MIN, {8'd0, r0});
        write_reg(esfs_pkg::CFG_RIGHT_MAX, {8'd0, r1});
        settings++;
        @(negedge clk);
    endtask

    // mostly advancing ticks, with open/close commands and noise mixed in
    task automatic queue_motion(input int n, input int unsigned step_max);
        int unsigned r;
        int          i;
        logic [1:0]  k;
        logic [31:0] t_ms;
        t_ms = $urandom();
        for (i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 4)
            begin
                k = 2'($urandom_range(3));
                push_req(k, $urandom());
            end
            else if (r < 7)
            begin
                push_req(REQ_UNUSED, t_ms);
            end
            else if (r < 9)
            begin
                t_ms = t_ms - $urandom_range(4 * step_max + 1);
                push_req(esfs_pkg::REQ_TICK, t_ms);
            end
            else if (r < 15)
            begin
                push_req($urandom_range(1) ? esfs_pkg::REQ_OPEN : esfs_pkg::REQ_CLOSE, t_ms);
            end
            else
            begin
                t_ms = t_ms + $urandom_range(step_max);
                push_req(esfs_pkg::REQ_TICK, t_ms);
            end
        end
    endtask

    initial
    begin : stimulus
        logic [15:0] o;
        logic [15:0] c;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = esfs_pkg::CFG_OPEN_TIME;
        cfg_ch.data     = '0;
        tx_idle_pct     = 9;
        rx_idle_pct     = 58;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: close from reset, full open cycle, wrap of the ms counter
        push_req(esfs_pkg::REQ_TICK, 32'd0);
        push_req(esfs_pkg::REQ_TICK, 32'd500);
        push_req(esfs_pkg::REQ_TICK, 32'd1000);
        push_req(esfs_pkg::REQ_TICK, 32'd1250);
        push_req(esfs_pkg::REQ_TICK, 32'd1500);
        push_req(esfs_pkg::REQ_TICK, 32'd1600);
        push_req(REQ_UNUSED, 32'd1700);
        push_req(esfs_pkg::REQ_OPEN, 32'd2000);
        push_req(esfs_pkg::REQ_TICK, 32'd2000);
        push_req(esfs_pkg::REQ_TICK, 32'd2250);
        push_req(esfs_pkg::REQ_TICK, 32'd2499);
        push_req(esfs_pkg::REQ_TICK, 32'd2500);
        push_req(esfs_pkg::REQ_TICK, 32'd3000);
        push_req(esfs_pkg::REQ_TICK, 32'd3499);
        push_req(esfs_pkg::REQ_TICK, 32'd3600);
        push_req(esfs_pkg::REQ_TICK, 32'd3700);
        push_req(esfs_pkg::REQ_CLOSE, 32'hFFFF_FFF0);
        push_req(esfs_pkg::REQ_TICK, 32'h0000_0100);
        push_req(REQ_UNUSED, 32'h0000_0200);
        push_req(esfs_pkg::REQ_TICK, 32'h0000_2000);
        push_req(esfs_pkg::REQ_TICK, 32'h0000_21F4);
        push_req(esfs_pkg::REQ_OPEN, 32'hFFFF_FFFF);
        push_req(esfs_pkg::REQ_CLOSE, 32'hFFFF_FFFF);
        push_req(esfs_pkg::REQ_OPEN, 32'h8000_0000);
        push_req(esfs_pkg::REQ_TICK, 32'h7FFF_FFFF);
        push_req(esfs_pkg::REQ_TICK, 32'h7FFF_FFFF);

        apply_setting(16'd40, 16'd20, 16'd60, 16'd25, 8'd10, 8'd170, 8'd170, 8'd10);
        queue_motion(100, 12);

        // shortest durations, full angle swing
        apply_setting(16'd1, 16'd1, 16'd1, 16'd1, 8'd0, 8'd180, 8'd180, 8'd0);
        queue_motion(80, 1);

        settle();
        tx_idle_pct = 58;
        rx_idle_pct = 9;
        // longest durations, min equal to max
        apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      8'd180, 8'd180, 8'd0, 8'd0);
        queue_motion(100, 20000);
        squeeze_go = 1'b1;

        // zero durations and angles above range
        apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 8'd255, 8'd200, 8'd0, 8'd255);
        queue_motion(80, 1);

        settle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_setting(16'($urandom_range(1, 200)), 16'($urandom_range(1, 200)),
                      16'($urandom_range(1, 200)), 16'($urandom_range(1, 200)),
                      8'($urandom_range(180)), 8'($urandom_range(180)),
                      8'($urandom_range(180)), 8'($urandom_range(180)));
        queue_motion(130, 30);

        o = 16'($urandom_range(65535));
        c = 16'($urandom_range(65535));
        apply_setting(o, 16'($urandom_range(65535)), c, 16'($urandom_range(65535)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)));
        queue_motion(130, ((o < c) ? o : c) / 3 + 1);

        settle();
        repeat (30) @(posedge clk);
        if (expect_q.size() != 0)
            mismatches += expect_q.size();
        $display("Run: %0d requests (ticks, commands, unused codes) over %0d register settings,",
                 issued, settings);
        $display("     %0d transactions checked, %0d mismatches", checked, mismatches);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
